// ===== sv/bitmap_block_allocator_assert.svh =====
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
package bba_pkg;

    localparam int BLK_W             = 12;
    localparam int CFG_W             = 13;
    localparam int NUM_BLOCKS_DEF    = 4096;
    localparam int MAP_WORD_BITS_DEF = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE_SEEK,
        S_FREE_CHK,
        S_RESP
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [BLK_W-1:0]   block_to_free;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0]   block_given;
        t_status            status;
    } t_rsp;

endpackage

// ===== sv/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bba_find_free.sv =====
module bba_find_free #(
    parameter int WB   = 64,
    parameter int RW   = 14,
    localparam int OW  = $clog2(WB)
) (
    input  logic [WB-1:0] i_word,
    input  logic [RW-1:0] i_remain,
    output logic          o_found,
    output logic          o_last,
    output logic [OW-1:0] o_idx,
    output logic [WB-1:0] o_onehot
);

    logic [WB-1:0] masked;
    logic [WB-1:0] lowest;

    // Bits at or beyond the count in use read as taken
    always_comb begin
        for (int i = 0; i < WB; i++) begin
            masked[i] = i_word[i] | (RW'(i) >= i_remain);
        end
    end

    // Isolate the lowest clear bit with a single carry chain
    assign lowest   = ~masked & (masked + WB'(1));
    assign o_found  = |lowest;
    assign o_onehot = lowest;
    assign o_last   = (i_remain <= RW'(WB));

    always_comb begin
        o_idx = '0;
        for (int k = 0; k < OW; k++) begin
            for (int i = 0; i < WB; i++) begin
                if (((i >> k) & 1) == 1) begin
                    o_idx[k] = o_idx[k] | lowest[i];
                end
            end
        end
    end

endmodule

// ===== sv/bitmap_block_allocator.sv =====
// First-fit block allocator over a used map of one bit per block.
// Request channel (i_req_valid / o_req_stall, payload i_req): func selects
// allocate or free; a request is taken when valid is high and stall low.
// Response channel (o_rsp_valid / i_rsp_stall, payload o_rsp): one response
// per request, held until the receiver drops stall.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets blocks_in_use;
// it is always ready and should be written only while the block is idle.
// Allocate: the map is read one word per cycle through the single RAM read
// port; the response is valid once the word holding the lowest free block
// is checked, or the last word below the count if none is free.
// Free: the target word is located by stepping one word per cycle, then
// read and checked; an out-of-range number or a zero count answers in the
// cycle after acceptance.
// One request is in flight at a time; stall stays high until the response is
// taken. After reset a clearing pass writes zero to every map word (64 by
// default), with stall high; config writes are still taken.
// A stalled response holds its value and blocks new requests.
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator #(
    parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_stall,
    input  bba_pkg::t_req             i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_stall,
    output bba_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bba_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OW        = $clog2(MAP_WORD_BITS);
    localparam int LIM_W     = ($clog2(NUM_BLOCKS + 1) > bba_pkg::CFG_W) ?
                               $clog2(NUM_BLOCKS + 1) : bba_pkg::CFG_W;
    localparam int BASE_W    = LIM_W + 1;

    bba_pkg::t_state r_state, n_state;

    logic [bba_pkg::CFG_W-1:0] r_cfg;
    logic [bba_pkg::BLK_W-1:0] r_blk, n_blk;
    logic [AW-1:0]             r_word, n_word;
    logic [BASE_W-1:0]         r_base, n_base;
    logic [AW-1:0]             r_chk_word, n_chk_word;
    logic [BASE_W-1:0]         r_chk_base, n_chk_base;
    logic                      r_chk_vld, n_chk_vld;
    bba_pkg::t_rsp             r_rsp, n_rsp;

    logic [LIM_W-1:0]          cfg_ext;
    logic [LIM_W-1:0]          lim;
    logic [BASE_W-1:0]         lim_b;
    logic                      req_acc;
    logic [BASE_W-1:0]         req_blk_b;
    logic [BASE_W-1:0]         blk_b;
    logic                      seek_hit;
    logic [BASE_W-1:0]         free_diff;
    logic [OW-1:0]             free_off;
    logic [BASE_W-1:0]         alloc_sum;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [MAP_WORD_BITS-1:0]  ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [MAP_WORD_BITS-1:0]  ram_rdata;

    logic                      ff_found;
    logic                      ff_last;
    logic [OW-1:0]             ff_idx;
    logic [MAP_WORD_BITS-1:0]  ff_onehot;

    // Counts above the map saturate to its size
    assign cfg_ext   = LIM_W'(r_cfg);
    assign lim       = (cfg_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : cfg_ext;
    assign lim_b     = BASE_W'(lim);
    assign req_acc   = i_req_valid && (r_state == bba_pkg::S_IDLE);
    assign req_blk_b = BASE_W'(i_req.block_to_free);
    assign blk_b     = BASE_W'(r_blk);
    assign seek_hit  = blk_b < (r_base + BASE_W'(MAP_WORD_BITS));
    assign free_diff = blk_b - r_chk_base;
    assign free_off  = free_diff[OW-1:0];
    assign alloc_sum = r_chk_base + BASE_W'(ff_idx);

    bba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_find_free #(
        .WB (MAP_WORD_BITS),
        .RW (BASE_W)
    ) u_find (
        .i_word   (ram_rdata),
        .i_remain (lim_b - r_chk_base),
        .o_found  (ff_found),
        .o_last   (ff_last),
        .o_idx    (ff_idx),
        .o_onehot (ff_onehot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                if (r_word == AW'(MAP_WORDS - 1)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (req_acc) begin
                    if (i_req.func == bba_pkg::FN_ALLOC) begin
                        n_state = (lim == '0) ? bba_pkg::S_RESP : bba_pkg::S_ALLOC;
                    end else begin
                        n_state = (req_blk_b >= lim_b) ? bba_pkg::S_RESP
                                                       : bba_pkg::S_FREE_SEEK;
                    end
                end
            end
            bba_pkg::S_ALLOC: begin
                if (r_chk_vld && (ff_found || ff_last)) begin
                    n_state = bba_pkg::S_RESP;
                end
            end
            bba_pkg::S_FREE_SEEK: begin
                if (seek_hit) begin
                    n_state = bba_pkg::S_FREE_CHK;
                end
            end
            bba_pkg::S_FREE_CHK: begin
                n_state = bba_pkg::S_RESP;
            end
            bba_pkg::S_RESP: begin
                if (!i_rsp_stall) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_blk      = r_blk;
        n_word     = r_word;
        n_base     = r_base;
        n_chk_word = r_chk_word;
        n_chk_base = r_chk_base;
        n_chk_vld  = r_chk_vld;
        n_rsp      = r_rsp;
        ram_we     = 1'b0;
        ram_waddr  = r_chk_word;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_word;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_word;
                n_word    = r_word + AW'(1);
            end
            bba_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_blk     = i_req.block_to_free;
                    n_word    = '0;
                    n_base    = '0;
                    n_chk_vld = 1'b0;
                    n_rsp.block_given = '0;
                    n_rsp.status = (i_req.func == bba_pkg::FN_ALLOC) ? bba_pkg::ST_FULL
                                                                     : bba_pkg::ST_RANGE;
                end
            end
            bba_pkg::S_ALLOC: begin
                // Issue the next word while checking the one read last cycle
                ram_re     = r_base < lim_b;
                n_chk_vld  = r_base < lim_b;
                n_chk_word = r_word;
                n_chk_base = r_base;
                n_word     = r_word + AW'(1);
                n_base     = r_base + BASE_W'(MAP_WORD_BITS);
                if (r_chk_vld) begin
                    if (ff_found) begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | ff_onehot;
                        n_rsp.block_given = alloc_sum[bba_pkg::BLK_W-1:0];
                        n_rsp.status      = bba_pkg::ST_OK;
                        n_chk_vld = 1'b0;
                    end else if (ff_last) begin
                        n_rsp.block_given = '0;
                        n_rsp.status      = bba_pkg::ST_FULL;
                        n_chk_vld = 1'b0;
                    end
                end
            end
            bba_pkg::S_FREE_SEEK: begin
                if (seek_hit) begin
                    ram_re     = 1'b1;
                    n_chk_word = r_word;
                    n_chk_base = r_base;
                end else begin
                    n_word = r_word + AW'(1);
                    n_base = r_base + BASE_W'(MAP_WORD_BITS);
                end
            end
            bba_pkg::S_FREE_CHK: begin
                n_rsp.block_given = '0;
                if (ram_rdata[free_off]) begin
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata & ~(MAP_WORD_BITS'(1) << free_off);
                    n_rsp.status = bba_pkg::ST_OK;
                end else begin
                    n_rsp.status = bba_pkg::ST_DOUBLE_FREE;
                end
            end
            bba_pkg::S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bba_pkg::S_CLEAR;
            r_cfg     <= bba_pkg::CFG_RESET;
            r_word    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_word    <= n_word;
            r_chk_vld <= n_chk_vld;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk      <= n_blk;
        r_base     <= n_base;
        r_chk_word <= n_chk_word;
        r_chk_base <= n_chk_base;
        r_rsp      <= n_rsp;
    end

    assign o_req_stall = (r_state != bba_pkg::S_IDLE);
    assign o_rsp_valid = (r_state == bba_pkg::S_RESP);
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

    `BBA_ASSERT_IMP(a_map_write_state, i_clk, i_rst_n, ram_we,
        (r_state == bba_pkg::S_CLEAR) || (r_state == bba_pkg::S_ALLOC) ||
        (r_state == bba_pkg::S_FREE_CHK), "map written outside clear, alloc or free")
    `BBA_ASSERT_NXT(a_req_leaves_idle, i_clk, i_rst_n, req_acc,
        r_state != bba_pkg::S_IDLE, "accepted request did not start")
    `BBA_ASSERT_IMP(a_check_in_limit, i_clk, i_rst_n,
        (r_state == bba_pkg::S_ALLOC) && r_chk_vld, r_chk_base < lim_b,
        "scan checked a word beyond the count in use")
    `BBA_ASSERT_IMP(a_fail_gives_zero, i_clk, i_rst_n,
        o_rsp_valid && (r_rsp.status != bba_pkg::ST_OK), r_rsp.block_given == '0,
        "failed request returned a block number")

endmodule

// ===== tb/bitmap_block_allocator_tb.sv =====
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int MAP_WORDS    = NUM_BLOCKS_DEF / MAP_WORD_BITS_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int FILL_PHASE   = 6;
    localparam int FILL_COUNT   = 256;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        bit               is_count;
        logic [CFG_W-1:0] count;
        t_req             req;
        bit               typed;
        t_rsp             rsp;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    t_req             req_data = '0;
    logic             rsp_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             o_req_stall;
    logic             o_rsp_valid;
    t_rsp             o_rsp;
    logic             o_cfg_ready;

    // shadow copy of the used map and the block count
    logic [MAP_WORD_BITS_DEF-1:0] shadow_map [MAP_WORDS];
    int        shadow_count;
    int        shadow_used;
    t_rsp      outcome_q[$];
    plan_row_t plan_q[$];
    int        failures = 0;
    int        hold_left = 0;
    bit        quiet_run = 1'b0;

    bitmap_block_allocator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (req_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int count_limit();
        return (shadow_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : shadow_count;
    endfunction

    function automatic bit block_used(input int b);
        return shadow_map[b / MAP_WORD_BITS_DEF][b % MAP_WORD_BITS_DEF];
    endfunction

    // First fit from block 0 on allocate; range and double-free checks on free
    function automatic t_rsp next_outcome(input t_req r);
        t_rsp res;
        int   lim;
        int   b;
        lim = count_limit();
        res.block_given = '0;
        res.status = ST_OK;
        if (r.func == FN_ALLOC) begin
            res.status = ST_FULL;
            b = 0;
            while (b < lim && res.status == ST_FULL) begin
                if (!block_used(b)) begin
                    shadow_map[b / MAP_WORD_BITS_DEF][b % MAP_WORD_BITS_DEF] = 1'b1;
                    shadow_used++;
                    res.block_given = b[BLK_W-1:0];
                    res.status = ST_OK;
                end
                b++;
            end
        end else begin
            b = int'(r.block_to_free);
            if (b >= lim) begin
                res.status = ST_RANGE;
            end else if (!block_used(b)) begin
                res.status = ST_DOUBLE_FREE;
            end else begin
                shadow_map[b / MAP_WORD_BITS_DEF][b % MAP_WORD_BITS_DEF] = 1'b0;
                shadow_used--;
            end
        end
        return res;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run) return 0;
        if (r < 80) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Mostly blocks in use, some free ones in range, some anywhere
    function automatic logic [BLK_W-1:0] pick_free_target();
        int          lim;
        int          hi;
        int          tries;
        logic [31:0] b;
        lim = count_limit();
        b = $urandom_range(0, NUM_BLOCKS_DEF - 1);
        if (lim == 0 || $urandom_range(0, 99) < 15) return b[BLK_W-1:0];
        hi = ($urandom_range(0, 1) == 0 && lim > 256) ? 256 : lim;
        b = $urandom_range(0, hi - 1);
        if ($urandom_range(0, 99) < 80) begin
            for (tries = 0; tries < 16 && !block_used(int'(b)); tries++)
                b = $urandom_range(0, hi - 1);
        end
        return b[BLK_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_count();
        logic [31:0] n;
        case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = $urandom_range(1, 3);
            2:       n = 64;
            3:       n = 65;
            4:       n = $urandom_range(60, 200);
            5:       n = NUM_BLOCKS_DEF;
            6:       n = $urandom_range(NUM_BLOCKS_DEF + 1, (1 << CFG_W) - 1);
            7:       n = NUM_BLOCKS_DEF - 1;
            default: n = $urandom_range(4, 130);
        endcase
        return n[CFG_W-1:0];
    endfunction

    task automatic add_count(input int n);
        plan_row_t row;
        row.is_count = 1'b1;
        row.count = n[CFG_W-1:0];
        row.req = '0;
        row.typed = 1'b0;
        row.rsp = '0;
        plan_q.push_back(row);
    endtask

    task automatic add_req(input t_func f, input int blk, input bit typed,
                           input int given, input t_status st);
        plan_row_t row;
        row.is_count = 1'b0;
        row.count = '0;
        row.req.func = f;
        row.req.block_to_free = blk[BLK_W-1:0];
        row.typed = typed;
        row.rsp.block_given = given[BLK_W-1:0];
        row.rsp.status = st;
        plan_q.push_back(row);
    endtask

    task automatic set_block_count(input logic [CFG_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (o_cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_count = int'(n);
    endtask

    // Hold the payload until stall drops, then log what the block owes
    task automatic send_request(input t_req r, input bit typed, input t_rsp fixed);
        int   gap;
        t_rsp pred;
        gap = ($urandom_range(0, 1) == 0) ? 0 : pick_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (o_req_stall !== 1'b0) @(posedge clk);
        pred = next_outcome(r);
        outcome_q.push_back(typed ? fixed : pred);
    endtask

    task automatic send_random(input int alloc_pct);
        t_req        r;
        logic [31:0] blk;
        blk = $urandom_range(0, NUM_BLOCKS_DEF - 1);
        r.func = ($urandom_range(0, 99) < alloc_pct) ? FN_ALLOC : FN_FREE;
        r.block_to_free = (r.func == FN_ALLOC) ? blk[BLK_W-1:0] : pick_free_target();
        send_request(r, 1'b0, '0);
    endtask

    task automatic wait_for_replies();
        req_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
    endtask

    task automatic check_response(input t_rsp got);
        t_rsp want;
        if (outcome_q.size() == 0) begin
            $error("response with no request pending: block_given %0d status %0d",
                   got.block_given, got.status);
            failures++;
        end else begin
            want = outcome_q.pop_front();
            if (got.block_given !== want.block_given) begin
                $error("block_given: expected %0d, got %0d", want.block_given,
                       got.block_given);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && o_rsp_valid === 1'b1 && !rsp_stall) check_response(o_rsp);
        if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
        end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
            hold_left = pick_len() - 1;
            rsp_stall <= 1'b1;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && o_req_stall === 1'b0) || (o_rsp_valid === 1'b1 && !rsp_stall)
                    || (cfg_valid && o_cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int        done_items;
        int        phase;
        int        n;
        int        k;
        int        w;
        plan_row_t row;
        for (w = 0; w < MAP_WORDS; w++) shadow_map[w] = '0;
        shadow_count = int'(CFG_RESET);
        shadow_used = 0;

        add_req(FN_ALLOC, 0, 1'b1, 0, ST_OK);
        add_req(FN_ALLOC, 12'hFFF, 1'b0, 0, ST_OK);
        add_req(FN_FREE, 0, 1'b1, 0, ST_OK);
        add_req(FN_FREE, 0, 1'b1, 0, ST_DOUBLE_FREE);
        add_req(FN_ALLOC, 0, 1'b1, 0, ST_OK);
        add_req(FN_FREE, 4095, 1'b1, 0, ST_DOUBLE_FREE);
        // zero count: nothing to search, nothing freeable
        add_count(0);
        add_req(FN_ALLOC, 0, 1'b1, 0, ST_FULL);
        add_req(FN_FREE, 0, 1'b1, 0, ST_RANGE);
        add_req(FN_FREE, 4095, 1'b1, 0, ST_RANGE);
        // count above the map saturates
        add_count((1 << CFG_W) - 1);
        add_req(FN_FREE, 4095, 1'b1, 0, ST_DOUBLE_FREE);
        add_req(FN_ALLOC, 0, 1'b1, 2, ST_OK);
        add_count(3);
        add_req(FN_ALLOC, 0, 1'b1, 0, ST_FULL);
        add_req(FN_FREE, 3, 1'b1, 0, ST_RANGE);
        add_req(FN_FREE, 2, 1'b1, 0, ST_OK);
        add_req(FN_ALLOC, 0, 1'b0, 0, ST_OK);
        // shrink: block 1 stays used but is out of reach
        add_count(1);
        add_req(FN_FREE, 1, 1'b1, 0, ST_RANGE);
        add_req(FN_ALLOC, 0, 1'b1, 0, ST_FULL);
        add_count(NUM_BLOCKS_DEF + 1);
        add_req(FN_ALLOC, 0, 1'b0, 0, ST_OK);
        add_req(FN_FREE, 1, 1'b1, 0, ST_OK);
        add_req(FN_FREE, 12'hAAA, 1'b1, 0, ST_DOUBLE_FREE);
        add_req(FN_FREE, 12'h555, 1'b1, 0, ST_DOUBLE_FREE);
        add_count(NUM_BLOCKS_DEF);
        add_req(FN_ALLOC, 12'h555, 1'b0, 0, ST_OK);
        add_req(FN_ALLOC, 0, 1'b0, 0, ST_OK);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan_q[k]) begin
            row = plan_q[k];
            if (row.is_count) begin
                wait_for_replies();
                set_block_count(row.count);
            end else begin
                send_request(row.req, row.typed, row.rsp);
            end
        end

        done_items = 0;
        phase = 0;
        while (done_items < RANDOM_ITEMS) begin
            wait_for_replies();
            if (phase == FILL_PHASE) begin
                // fill every block below the count, overrun it, then punch holes
                set_block_count(CFG_W'(FILL_COUNT));
                quiet_run = 1'b0;
                repeat (FILL_COUNT) send_random(100);
                repeat (3) send_random(100);
                repeat (100) send_random(0);
                done_items += FILL_COUNT + 103;
            end else begin
                set_block_count(pick_count());
                quiet_run = ($urandom_range(0, 5) == 0);
                n = $urandom_range(30, 120);
                for (k = 0; k < n; k++) begin
                    if (k > 0 && $urandom_range(0, 39) == 0) wait_for_replies();
                    send_random(55);
                end
                done_items += n;
            end
            phase++;
        end

        quiet_run = 1'b0;
        wait_for_replies();
        repeat (80) @(posedge clk);
        if (failures == 0 && outcome_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
